>>> design/imcaf_pkg.sv
// constants, op codes and helpers for the complementary attitude filter
// used by imu_complementary_attitude_filter_unit; depends on nothing else
package imcaf_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TABLE_LEN        = 24;

    localparam logic signed [33:0] DEG90  = 34'sd377487360;
    localparam logic signed [33:0] DEG180 = 34'sd754974720;
    localparam logic signed [33:0] DEG360 = 34'sd1509949440;
    localparam logic signed [33:0] INV_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [32:0] GYRO_K_Q16 = 33'sd7690109;
    localparam logic signed [32:0] SCALE_100  = 33'sd100;

    localparam logic [15:0] GYRO_WEIGHT_RST = 16'd62915;
    localparam logic [11:0] GRAVITY_RST     = 12'd2511;

    typedef enum logic [7:0] {
        REG_GYRO_WEIGHT = 8'd0,
        REG_GRAVITY     = 8'd1
    } reg_idx_t;

    // multiplier sequence; pitch half, roll half, then gravity and outputs
    typedef enum logic [4:0] {
        OP_P_RXMS = 5'd0,
        OP_P_TK   = 5'd1,
        OP_P_WDL  = 5'd2,
        OP_P_WDH  = 5'd3,
        OP_R_RYMS = 5'd4,
        OP_R_TK   = 5'd5,
        OP_R_WDL  = 5'd6,
        OP_R_WDH  = 5'd7,
        OP_GY     = 5'd8,
        OP_GX     = 5'd9,
        OP_CC     = 5'd10,
        OP_GZ     = 5'd11,
        OP_O_P    = 5'd12,
        OP_O_R    = 5'd13,
        OP_O_X    = 5'd14,
        OP_O_Y    = 5'd15,
        OP_O_Z    = 5'd16
    } mop_t;

    // atan(2^-i) in Q6.22 degrees
    function automatic logic [27:0] atan_q22(input logic [4:0] idx);
        logic [27:0] v;
        case (idx)
            5'd0:  v = 28'd188743680;
            5'd1:  v = 28'd111421900;
            5'd2:  v = 28'd58872272;
            5'd3:  v = 28'd29884485;
            5'd4:  v = 28'd15000234;
            5'd5:  v = 28'd7507429;
            5'd6:  v = 28'd3754631;
            5'd7:  v = 28'd1877430;
            5'd8:  v = 28'd938729;
            5'd9:  v = 28'd469366;
            5'd10: v = 28'd234683;
            5'd11: v = 28'd117342;
            5'd12: v = 28'd58671;
            5'd13: v = 28'd29335;
            5'd14: v = 28'd14668;
            5'd15: v = 28'd7334;
            5'd16: v = 28'd3667;
            5'd17: v = 28'd1833;
            5'd18: v = 28'd917;
            5'd19: v = 28'd458;
            5'd20: v = 28'd229;
            5'd21: v = 28'd115;
            5'd22: v = 28'd57;
            5'd23: v = 28'd29;
            default: v = 28'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [65:0] v);
        logic signed [15:0] r;
        if (v > 66'sd32767)
            r = 16'sh7fff;
        else if (v < -66'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage

>>> design/imu_complementary_attitude_filter_unit.sv
// complementary-filter attitude estimator with one shared cordic stage and one multiplier
// depends on imcaf_pkg
//
// channel   dir  handshake              payload
// s_axis    in   s_tvalid / s_tready    s_tdata: ax, ay, az, rx, ry, elapsed_ms
// m_axis    out  m_tvalid / m_tready    m_tdata: pitch, roll, lin_x, lin_y, lin_z
// cfg       in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one beat runs two atan2 and two sin/cos runs on the cordic stage and 17 products on the one
// multiplier, each computed and then written back, an angle reduction before each sin/cos run,
// done and idle; a seeding beat runs only the two atan2 runs and returns to idle with no output
// s_tready is high only while idle; a finished result waits in the output register and the
// next beat may run meanwhile; a result stalls in the last step only if that register is full
// rst_n clears the filter state, the registers to defaults and all handshakes
module imu_complementary_attitude_filter_unit #(
    parameter int CORDIC_STEPS = imcaf_pkg::CORDIC_STEPS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // accel_x, accel_y, accel_z, rate_x, rate_y, elapsed_ms
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // pitch_centideg, roll_centideg, linear_x/y/z_centi
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [IW-1:0] LAST_IT = IW'(CORDIC_STEPS - 1);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_ATAN = 7'b0000010,
        ST_MULA = 7'b0000100,
        ST_RED  = 7'b0001000,
        ST_ROT  = 7'b0010000,
        ST_MULB = 7'b0100000,
        ST_DONE = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] gyro_weight_reg;
    logic [11:0] gravity_reg;
    logic signed [31:0] pitch_reg, roll_reg;
    logic seeded_reg;

    logic signed [15:0] ax_reg, ay_reg, az_reg, rx_reg, ry_reg;
    logic [15:0] ms_reg;
    logic signed [31:0] acc_p_reg, acc_r_reg;

    logic signed [33:0] cx_reg, cy_reg, cz_reg;
    logic [IW-1:0] iter_reg;
    logic sub_reg, zero_reg, neg_reg;

    imcaf_pkg::mop_t op_reg;
    logic mph_reg;
    logic signed [65:0] prod_reg;
    logic signed [32:0] t_reg;
    logic signed [41:0] d_reg;
    logic signed [63:0] acc64_reg;
    logic signed [32:0] sp_reg, cp_reg, sr_reg, cr_reg, czz_reg;
    logic signed [15:0] gx_reg, gy_reg, gz_reg;
    logic signed [15:0] o0_reg, o1_reg, o2_reg, o3_reg, o4_reg;

    logic        m_tvalid_reg;
    logic [79:0] m_tdata_reg;

    // cordic stage
    logic signed [33:0] sh_x, sh_y, tbl, cx_n, cy_n, cz_n;
    logic sig_pos;

    always_comb
    begin
        sh_x = cx_reg >>> iter_reg;
        sh_y = cy_reg >>> iter_reg;
        tbl  = signed'({6'd0, imcaf_pkg::atan_q22(5'(iter_reg))});
        sig_pos = (state_reg == ST_ROT) ? !cz_reg[33] : !(cy_reg > 34'sd0);
        if (sig_pos)
        begin
            cx_n = cx_reg - sh_y;
            cy_n = cy_reg + sh_x;
            cz_n = cz_reg - tbl;
        end
        else
        begin
            cx_n = cx_reg + sh_y;
            cy_n = cy_reg - sh_x;
            cz_n = cz_reg + tbl;
        end
    end

    // atan2 start: source is the input beat for pitch, latched beat for roll
    logic signed [16:0] ai_y, ai_x;
    logic signed [33:0] ai_cx, ai_cy, ai_cz;
    logic ai_zero;

    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            ai_y = 17'(signed'(s_tdata[31:16]));
            ai_x = 17'(signed'(s_tdata[47:32]));
        end
        else
        begin
            ai_y = -17'(ax_reg);
            ai_x = 17'(az_reg);
        end
        ai_zero = (ai_x == 17'sd0) && (ai_y == 17'sd0);
        if (ai_x < 17'sd0)
        begin
            ai_cz = (ai_y >= 17'sd0) ? imcaf_pkg::DEG180 : -imcaf_pkg::DEG180;
            ai_cx = 34'(-ai_x) <<< 14;
            ai_cy = 34'(-ai_y) <<< 14;
        end
        else
        begin
            ai_cz = 34'sd0;
            ai_cx = 34'(ai_x) <<< 14;
            ai_cy = 34'(ai_y) <<< 14;
        end
    end

    // angle reduction into [-180,180) and fold into [-90,90]
    logic signed [33:0] red_a, fold_a;
    logic fold_neg, red_done;

    always_comb
    begin
        red_done = (cz_reg < imcaf_pkg::DEG360) && !cz_reg[33];
        red_a = cz_reg - imcaf_pkg::DEG180;
        if (red_a > imcaf_pkg::DEG90)
        begin
            fold_a = red_a - imcaf_pkg::DEG180;
            fold_neg = 1'b1;
        end
        else if (red_a < -imcaf_pkg::DEG90)
        begin
            fold_a = red_a + imcaf_pkg::DEG180;
            fold_neg = 1'b1;
        end
        else
        begin
            fold_a = red_a;
            fold_neg = 1'b0;
        end
    end

    // shared multiplier operands
    logic signed [32:0] mul_a, mul_b;
    logic signed [32:0] w_s, g_s;
    logic signed [17:0] lin_d;

    always_comb
    begin
        w_s = signed'({17'd0, gyro_weight_reg});
        g_s = signed'({21'd0, gravity_reg});
        lin_d = 18'sd0;
        mul_a = 33'sd0;
        mul_b = 33'sd0;
        case (op_reg)
            imcaf_pkg::OP_P_RXMS:
            begin
                mul_a = 33'(rx_reg);
                mul_b = signed'({17'd0, ms_reg});
            end
            imcaf_pkg::OP_R_RYMS:
            begin
                mul_a = 33'(ry_reg);
                mul_b = signed'({17'd0, ms_reg});
            end
            imcaf_pkg::OP_P_TK, imcaf_pkg::OP_R_TK:
            begin
                mul_a = t_reg;
                mul_b = imcaf_pkg::GYRO_K_Q16;
            end
            imcaf_pkg::OP_P_WDL, imcaf_pkg::OP_R_WDL:
            begin
                mul_a = signed'({12'd0, d_reg[20:0]});
                mul_b = w_s;
            end
            imcaf_pkg::OP_P_WDH, imcaf_pkg::OP_R_WDH:
            begin
                mul_a = 33'(signed'(d_reg[41:21]));
                mul_b = w_s;
            end
            imcaf_pkg::OP_GY:
            begin
                mul_a = sp_reg;
                mul_b = g_s;
            end
            imcaf_pkg::OP_GX:
            begin
                mul_a = sr_reg;
                mul_b = g_s;
            end
            imcaf_pkg::OP_CC:
            begin
                mul_a = cr_reg;
                mul_b = cp_reg;
            end
            imcaf_pkg::OP_GZ:
            begin
                mul_a = czz_reg;
                mul_b = g_s;
            end
            imcaf_pkg::OP_O_P:
            begin
                mul_a = 33'(pitch_reg);
                mul_b = imcaf_pkg::SCALE_100;
            end
            imcaf_pkg::OP_O_R:
            begin
                mul_a = 33'(roll_reg);
                mul_b = imcaf_pkg::SCALE_100;
            end
            imcaf_pkg::OP_O_X:
            begin
                lin_d = 18'(ax_reg) - 18'(gx_reg);
                mul_a = 33'(lin_d);
                mul_b = imcaf_pkg::SCALE_100;
            end
            imcaf_pkg::OP_O_Y:
            begin
                lin_d = 18'(ay_reg) - 18'(gy_reg);
                mul_a = 33'(lin_d);
                mul_b = imcaf_pkg::SCALE_100;
            end
            imcaf_pkg::OP_O_Z:
            begin
                lin_d = 18'(az_reg) - 18'(gz_reg);
                mul_a = 33'(lin_d);
                mul_b = imcaf_pkg::SCALE_100;
            end
            default:
            begin
                mul_a = 33'sd0;
                mul_b = 33'sd0;
            end
        endcase
    end

    // product writeback helpers
    logic signed [65:0] rnd16, rnd30, rnd22, rnd8;
    logic signed [41:0] gyro_inc;
    logic signed [63:0] bl_sum, bl_rnd;
    logic signed [47:0] bl_val;
    logic signed [31:0] bl_sat, acc_sel, ang_sel;

    always_comb
    begin
        rnd16 = (prod_reg + 66'sd32768) >>> 16;
        rnd30 = (prod_reg + (66'sd1 <<< 29)) >>> 30;
        rnd22 = (prod_reg + (66'sd1 <<< 21)) >>> 22;
        rnd8  = (prod_reg + 66'sd128) >>> 8;
        gyro_inc = rnd16[41:0];
        acc_sel = (op_reg == imcaf_pkg::OP_P_TK || op_reg == imcaf_pkg::OP_P_WDH) ?
                  acc_p_reg : acc_r_reg;
        ang_sel = (op_reg == imcaf_pkg::OP_P_TK) ? pitch_reg : roll_reg;
        bl_sum = acc64_reg + (prod_reg[63:0] <<< 21);
        bl_rnd = (bl_sum + 64'sd32768) >>> 16;
        bl_val = 48'(bl_rnd) + 48'(acc_sel);
        if (bl_val > 48'sh7fffffff)
            bl_sat = 32'sh7fffffff;
        else if (bl_val < -48'sh80000000)
            bl_sat = 32'sh80000000;
        else
            bl_sat = bl_val[31:0];
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    logic out_free;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (s_tvalid)
                    state_next = ST_ATAN;
            ST_ATAN:
                if (iter_reg == LAST_IT && sub_reg)
                    state_next = seeded_reg ? ST_MULA : ST_IDLE;
            ST_MULA:
                if (mph_reg && op_reg == imcaf_pkg::OP_R_WDH)
                    state_next = ST_RED;
            ST_RED:
                if (red_done)
                    state_next = ST_ROT;
            ST_ROT:
                if (iter_reg == LAST_IT)
                    state_next = sub_reg ? ST_MULB : ST_RED;
            ST_MULB:
                if (mph_reg && op_reg == imcaf_pkg::OP_O_Z)
                    state_next = ST_DONE;
            ST_DONE:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            gyro_weight_reg <= imcaf_pkg::GYRO_WEIGHT_RST;
            gravity_reg     <= imcaf_pkg::GRAVITY_RST;
            pitch_reg       <= 32'sd0;
            roll_reg        <= 32'sd0;
            seeded_reg      <= 1'b0;
            iter_reg        <= '0;
            sub_reg         <= 1'b0;
            op_reg          <= imcaf_pkg::OP_P_RXMS;
            mph_reg         <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    imcaf_pkg::REG_GYRO_WEIGHT: gyro_weight_reg <= cfg_data;
                    imcaf_pkg::REG_GRAVITY:     gravity_reg <= cfg_data[11:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_DONE && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tvalid_reg && m_tready)
                m_tvalid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    iter_reg <= '0;
                    sub_reg  <= 1'b0;
                end
                ST_ATAN:
                begin
                    if (iter_reg == LAST_IT)
                    begin
                        iter_reg <= '0;
                        sub_reg  <= !sub_reg;
                        if (sub_reg && !seeded_reg)
                        begin
                            pitch_reg  <= acc_p_reg;
                            roll_reg   <= zero_reg ? 32'sd0 : cz_n[31:0];
                            seeded_reg <= 1'b1;
                        end
                        if (sub_reg)
                        begin
                            op_reg  <= imcaf_pkg::OP_P_RXMS;
                            mph_reg <= 1'b0;
                        end
                    end
                    else
                        iter_reg <= iter_reg + 1'b1;
                end
                ST_MULA, ST_MULB:
                begin
                    mph_reg <= !mph_reg;
                    if (mph_reg)
                    begin
                        if (op_reg == imcaf_pkg::OP_P_WDH)
                            pitch_reg <= bl_sat;
                        if (op_reg == imcaf_pkg::OP_R_WDH)
                        begin
                            roll_reg <= bl_sat;
                            sub_reg  <= 1'b0;
                        end
                        if (op_reg != imcaf_pkg::OP_O_Z)
                            op_reg <= imcaf_pkg::mop_t'(op_reg + 5'd1);
                    end
                end
                ST_RED:
                    iter_reg <= '0;
                ST_ROT:
                begin
                    if (iter_reg == LAST_IT)
                    begin
                        iter_reg <= '0;
                        sub_reg  <= 1'b1;
                    end
                    else
                        iter_reg <= iter_reg + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                ax_reg <= signed'(s_tdata[15:0]);
                ay_reg <= signed'(s_tdata[31:16]);
                az_reg <= signed'(s_tdata[47:32]);
                rx_reg <= signed'(s_tdata[63:48]);
                ry_reg <= signed'(s_tdata[79:64]);
                ms_reg <= s_tdata[95:80];
                cx_reg <= ai_cx;
                cy_reg <= ai_cy;
                cz_reg <= ai_cz;
                zero_reg <= ai_zero;
            end
            ST_ATAN:
            begin
                if (iter_reg == LAST_IT && !sub_reg)
                begin
                    acc_p_reg <= zero_reg ? 32'sd0 : cz_n[31:0];
                    cx_reg <= ai_cx;
                    cy_reg <= ai_cy;
                    cz_reg <= ai_cz;
                    zero_reg <= ai_zero;
                end
                else
                begin
                    cx_reg <= cx_n;
                    cy_reg <= cy_n;
                    cz_reg <= cz_n;
                    if (iter_reg == LAST_IT)
                        acc_r_reg <= zero_reg ? 32'sd0 : cz_n[31:0];
                end
            end
            ST_MULA, ST_MULB:
            begin
                if (!mph_reg)
                    prod_reg <= mul_a * mul_b;
                else
                begin
                    case (op_reg)
                        imcaf_pkg::OP_P_RXMS, imcaf_pkg::OP_R_RYMS:
                            t_reg <= prod_reg[32:0];
                        imcaf_pkg::OP_P_TK, imcaf_pkg::OP_R_TK:
                            d_reg <= 42'(ang_sel) + gyro_inc - 42'(acc_sel);
                        imcaf_pkg::OP_P_WDL, imcaf_pkg::OP_R_WDL:
                            acc64_reg <= prod_reg[63:0];
                        imcaf_pkg::OP_R_WDH:
                            cz_reg <= 34'(pitch_reg) + imcaf_pkg::DEG180;
                        imcaf_pkg::OP_GY: gy_reg  <= rnd30[15:0];
                        imcaf_pkg::OP_GX: gx_reg  <= rnd30[15:0];
                        imcaf_pkg::OP_CC: czz_reg <= rnd30[32:0];
                        imcaf_pkg::OP_GZ: gz_reg  <= rnd30[15:0];
                        imcaf_pkg::OP_O_P: o0_reg <= imcaf_pkg::sat16(rnd22);
                        imcaf_pkg::OP_O_R: o1_reg <= imcaf_pkg::sat16(rnd22);
                        imcaf_pkg::OP_O_X: o2_reg <= imcaf_pkg::sat16(rnd8);
                        imcaf_pkg::OP_O_Y: o3_reg <= imcaf_pkg::sat16(rnd8);
                        imcaf_pkg::OP_O_Z: o4_reg <= imcaf_pkg::sat16(rnd8);
                        default: ;
                    endcase
                end
            end
            ST_RED:
            begin
                if (cz_reg >= imcaf_pkg::DEG360)
                    cz_reg <= cz_reg - imcaf_pkg::DEG360;
                else if (cz_reg[33])
                    cz_reg <= cz_reg + imcaf_pkg::DEG360;
                else
                begin
                    cz_reg  <= fold_a;
                    neg_reg <= fold_neg;
                    cx_reg  <= imcaf_pkg::INV_GAIN_Q30;
                    cy_reg  <= 34'sd0;
                end
            end
            ST_ROT:
            begin
                cx_reg <= cx_n;
                cy_reg <= cy_n;
                // pitch first, then the roll angle goes back through reduction
                if (iter_reg == LAST_IT && !sub_reg)
                    cz_reg <= 34'(roll_reg) + imcaf_pkg::DEG180;
                else
                    cz_reg <= cz_n;
                if (iter_reg == LAST_IT)
                begin
                    if (!sub_reg)
                    begin
                        sp_reg <= neg_reg ? -cy_n[32:0] : cy_n[32:0];
                        cp_reg <= neg_reg ? -cx_n[32:0] : cx_n[32:0];
                    end
                    else
                    begin
                        sr_reg <= neg_reg ? -cy_n[32:0] : cy_n[32:0];
                        cr_reg <= neg_reg ? -cx_n[32:0] : cx_n[32:0];
                    end
                end
            end
            ST_DONE:
                if (out_free)
                    m_tdata_reg <= {o4_reg, o3_reg, o2_reg, o1_reg, o0_reg};
            default: ;
        endcase
    end

endmodule
